### rtl/core/bpa_pkg.sv
// Shared constants for the bitmap page allocator: field widths, request
// modes and result status codes. No dependencies.
package bpa_pkg;

  localparam int unsigned CNT_W = 13;  // page counts, page_count register
  localparam int unsigned IDX_W = 12;  // page index and granted page fields
  localparam int unsigned STAT_W = 2;

  localparam logic [CNT_W-1:0] PAGE_COUNT_RESET = 13'd4096;

  typedef logic [STAT_W-1:0] status_t;

  localparam status_t STAT_OK = 2'd0;
  localparam status_t STAT_NO_SPACE = 2'd1;
  localparam status_t STAT_RANGE = 2'd2;
  localparam status_t STAT_ALREADY_FREE = 2'd3;

  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE = 1'b1;

endpackage

### rtl/core/bpa_word_ram.sv
// Bitmap word storage: one write port, one read port with registered data.
// Parameterized depth and width; no package dependencies.
module bpa_word_ram #(
  parameter int unsigned DEPTH = 128,
  parameter int unsigned WIDTH = 32,
  parameter int unsigned AW = 7
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

### rtl/core/bpa_word_unit.sv
// Shared word unit: lowest-zero search over one bitmap word, bit test, and
// the updated word for an allocate (set) or a free (clear). Uses bpa_pkg.
module bpa_word_unit #(
  parameter int unsigned WORD_BITS = 32,
  parameter int unsigned BIT_W = 5
) (
  input  logic [WORD_BITS-1:0] word,
  input  logic                 mode,
  input  logic [BIT_W-1:0]     bit_sel,
  output logic                 found,
  output logic [BIT_W-1:0]     zero_pos,
  output logic                 bit_val,
  output logic [WORD_BITS-1:0] new_word
);
  import bpa_pkg::*;

  // Scan from the top so the lowest zero bit is the last one to land.
  always_comb begin
    found = 1'b0;
    zero_pos = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (!word[i]) begin
        found = 1'b1;
        zero_pos = BIT_W'(i);
      end
    end
  end

  assign bit_val = word[bit_sel];

  always_comb begin
    if (mode == MODE_ALLOC) begin
      new_word = word | (WORD_BITS'(1) << zero_pos);
    end else begin
      new_word = word & ~(WORD_BITS'(1) << bit_sel);
    end
  end

endmodule

### rtl/core/bitmap_page_allocator.sv
// Bitmap first-fit page allocator, top level: request sequencer, counters,
// output register. Uses bpa_pkg, bpa_word_ram and bpa_word_unit.
//
// One request is handled at a time. After acceptance the block passes a
// setup state, then reads bitmap words from the word RAM one by one
// (an allocate reads words from page 0 up to the first free page, at most
// ceil(page limit / WORD_BITS) words, 128 at the defaults; a free reads
// words up to the one holding the page), writes the word back when the
// bitmap changes, and loads the output register once it is free. Range
// errors and an allocate with no managed pages answer right after setup. The
// single read port of the word RAM, one word per cycle, sets the scan time.
// After reset the bitmap is cleared by a sweep over all ceil(MAX_PAGES /
// WORD_BITS) words (128 at the defaults) during which no request is taken;
// configuration writes are taken at any time.
module bitmap_page_allocator #(
  parameter int unsigned MAX_PAGES = 4096,
  parameter int unsigned WORD_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  // configuration: page_count
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [bpa_pkg::CNT_W-1:0] cfg_data,
  // requests
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [11:0] page number to free, [15:12] zero
  input  logic        in_tuser,   // [0] mode
  // results
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [11:0] granted_page, [24:12] used_count,
                                  // [37:25] free_count, [39:38] zero
  output logic [1:0]  out_tuser   // [1:0] status
);
  import bpa_pkg::*;

  localparam int unsigned WORD_COUNT = (MAX_PAGES + WORD_BITS - 1) / WORD_BITS;
  localparam int unsigned WA_W = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
  localparam int unsigned BIT_W = $clog2(WORD_BITS);
  localparam int unsigned PG_W = WA_W + BIT_W;
  localparam int unsigned CMP_W = (PG_W + 1 > CNT_W + 1) ? PG_W + 1 : CNT_W + 1;

  typedef enum logic [5:0] {
    ST_CLEAR  = 6'b000001,
    ST_IDLE   = 6'b000010,
    ST_START  = 6'b000100,
    ST_SCAN   = 6'b001000,
    ST_UPDATE = 6'b010000,
    ST_RESP   = 6'b100000
  } state_t;

  state_t               state_r, state_nxt;
  logic [WA_W-1:0]      addr_r, addr_nxt;
  logic [CMP_W-1:0]     base_r, base_nxt;
  logic                 mode_r, mode_nxt;
  logic [IDX_W-1:0]     idx_r, idx_nxt;
  logic [WORD_BITS-1:0] wr_word_r, wr_word_nxt;
  status_t              stat_r, stat_nxt;
  logic [IDX_W-1:0]     grant_r, grant_nxt;
  logic [CNT_W-1:0]     used_total_r, used_total_nxt;
  logic [CNT_W-1:0]     page_count_r;
  logic                 out_valid_r, out_valid_nxt;
  status_t              out_stat_r, out_stat_nxt;
  logic [IDX_W-1:0]     out_grant_r, out_grant_nxt;
  logic [CNT_W-1:0]     out_used_r, out_used_nxt;
  logic [CNT_W-1:0]     out_free_r, out_free_nxt;

  logic [CNT_W-1:0]     limit;
  logic [CMP_W-1:0]     limit_w;
  logic [CMP_W-1:0]     idx_w;
  logic [CMP_W-1:0]     base_end;
  logic [CMP_W-1:0]     cand;
  logic [CNT_W-1:0]     free_now;
  logic [WA_W-1:0]      addr_inc;
  logic [BIT_W-1:0]     bit_sel;
  logic                 go_update;

  logic                 ram_we;
  logic [WA_W-1:0]      ram_raddr;
  logic [WORD_BITS-1:0] ram_wdata;
  logic [WORD_BITS-1:0] ram_rdata;

  logic                 unit_found;
  logic [BIT_W-1:0]     unit_zero_pos;
  logic                 unit_bit_val;
  logic [WORD_BITS-1:0] unit_new_word;

  // Effective page limit: the register, capped at the bitmap capacity.
  assign limit = (CMP_W'(page_count_r) > CMP_W'(MAX_PAGES)) ? CNT_W'(MAX_PAGES)
                                                             : page_count_r;
  assign limit_w = CMP_W'(limit);
  assign idx_w = CMP_W'(idx_r);
  assign base_end = base_r + CMP_W'(WORD_BITS);
  assign cand = base_r + CMP_W'(unit_zero_pos);
  assign bit_sel = BIT_W'(idx_w - base_r);
  assign free_now = (limit > used_total_r) ? (limit - used_total_r) : '0;
  assign addr_inc = (addr_r == WA_W'(WORD_COUNT - 1)) ? '0 : addr_r + 1'b1;

  assign ram_we = (state_r == ST_CLEAR) || (state_r == ST_UPDATE);
  assign ram_wdata = (state_r == ST_CLEAR) ? '0 : wr_word_r;
  // Prefetch the next word while the current one is checked.
  assign ram_raddr = (state_r == ST_SCAN) ? addr_inc : addr_r;

  bpa_word_ram #(
    .DEPTH(WORD_COUNT),
    .WIDTH(WORD_BITS),
    .AW   (WA_W)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(addr_r),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  bpa_word_unit #(
    .WORD_BITS(WORD_BITS),
    .BIT_W    (BIT_W)
  ) u_unit (
    .word    (ram_rdata),
    .mode    (mode_r),
    .bit_sel (bit_sel),
    .found   (unit_found),
    .zero_pos(unit_zero_pos),
    .bit_val (unit_bit_val),
    .new_word(unit_new_word)
  );

  assign go_update = (state_r == ST_SCAN) &&
                     (((mode_r == MODE_ALLOC) && unit_found && (cand < limit_w)) ||
                      ((mode_r == MODE_FREE) && (idx_w < base_end) && unit_bit_val));

  always_comb begin
    state_nxt = state_r;
    addr_nxt = addr_r;
    base_nxt = base_r;
    mode_nxt = mode_r;
    idx_nxt = idx_r;
    wr_word_nxt = wr_word_r;
    stat_nxt = stat_r;
    grant_nxt = grant_r;
    used_total_nxt = used_total_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_stat_nxt = out_stat_r;
    out_grant_nxt = out_grant_r;
    out_used_nxt = out_used_r;
    out_free_nxt = out_free_r;

    unique case (state_r)
      ST_CLEAR: begin
        if (addr_r == WA_W'(WORD_COUNT - 1)) begin
          addr_nxt = '0;
          state_nxt = ST_IDLE;
        end else begin
          addr_nxt = addr_inc;
        end
      end
      ST_IDLE: begin
        if (in_tvalid) begin
          mode_nxt = in_tuser;
          idx_nxt = in_tdata[IDX_W-1:0];
          addr_nxt = '0;
          base_nxt = '0;
          grant_nxt = '0;
          stat_nxt = STAT_OK;
          state_nxt = ST_START;
        end
      end
      ST_START: begin
        priority if (mode_r == MODE_ALLOC && limit == '0) begin
          stat_nxt = STAT_NO_SPACE;
          state_nxt = ST_RESP;
        end else if (mode_r == MODE_FREE && idx_w >= limit_w) begin
          stat_nxt = STAT_RANGE;
          state_nxt = ST_RESP;
        end else begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        priority if (go_update) begin
          wr_word_nxt = unit_new_word;
          if (mode_r == MODE_ALLOC) begin
            grant_nxt = cand[IDX_W-1:0];
          end
          state_nxt = ST_UPDATE;
        end else if (mode_r == MODE_FREE && idx_w < base_end) begin
          stat_nxt = STAT_ALREADY_FREE;
          state_nxt = ST_RESP;
        end else if (mode_r == MODE_ALLOC && base_end >= limit_w) begin
          stat_nxt = STAT_NO_SPACE;
          state_nxt = ST_RESP;
        end else begin
          addr_nxt = addr_inc;
          base_nxt = base_end;
        end
      end
      ST_UPDATE: begin
        if (mode_r == MODE_ALLOC) begin
          used_total_nxt = used_total_r + 1'b1;
        end else if (used_total_r != '0) begin
          used_total_nxt = used_total_r - 1'b1;
        end
        state_nxt = ST_RESP;
      end
      ST_RESP: begin
        // Hold the result until the output register is free.
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_stat_nxt = stat_r;
          out_grant_nxt = grant_r;
          out_used_nxt = used_total_r;
          out_free_nxt = free_now;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      addr_r <= '0;
      used_total_r <= '0;
      page_count_r <= PAGE_COUNT_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      addr_r <= addr_nxt;
      used_total_r <= used_total_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid) begin
        page_count_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    base_r <= base_nxt;
    mode_r <= mode_nxt;
    idx_r <= idx_nxt;
    wr_word_r <= wr_word_nxt;
    stat_r <= stat_nxt;
    grant_r <= grant_nxt;
    out_stat_r <= out_stat_nxt;
    out_grant_r <= out_grant_nxt;
    out_used_r <= out_used_nxt;
    out_free_r <= out_free_nxt;
  end

  assign cfg_ready = 1'b1;
  assign in_tready = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tuser = out_stat_r;
  assign out_tdata = {2'b00, out_free_r, out_used_r, out_grant_r};

`ifndef SYNTHESIS
  // A free that reaches the write cycle found its bit set, so the count is positive.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_UPDATE && mode_r == MODE_FREE) |-> (used_total_r != '0))
    else $error("free of a set bit with zero used count");

  // The bitmap update flips exactly one bit of the word read.
  assert property (@(posedge clk) disable iff (!rst_n)
    go_update |-> ($countones(unit_new_word ^ ram_rdata) == 1))
    else $error("bitmap update does not change exactly one bit");

  // A new result only comes out of the response state.
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == ST_RESP))
    else $error("result presented outside the response state");

  // No request is taken during the clearing sweep.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLEAR) |-> !in_tready)
    else $error("request accepted while the bitmap is being cleared");

  // A granted page lies below the effective page limit.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_UPDATE && mode_r == MODE_ALLOC) |-> (CMP_W'(grant_r) < limit_w))
    else $error("granted page beyond the page limit");
`endif

endmodule
